// ===== design/olst_pkg.sv =====
package olst_pkg;

	// fixed field widths of the request and result channels
	localparam int CMD_W   = 3;
	localparam int POS_W   = 6;
	localparam int WORD_W  = 64;
	localparam int STAT_W  = 2;
	localparam int IDX_W   = 6;
	localparam int CNT_W   = 7;

	// command codes
	localparam logic [CMD_W-1:0] CMD_PUSH_TAIL = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_HEAD = 3'd1;
	localparam logic [CMD_W-1:0] CMD_INSERT_AT = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_TAIL  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_POP_HEAD  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_REMOVE_AT = 3'd5;
	localparam logic [CMD_W-1:0] CMD_FIND      = 3'd6;
	localparam logic [CMD_W-1:0] CMD_READ_AT   = 3'd7;

	// status codes
	localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd2;
	localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd3;

	// finished result handed from the sequencer to the output register
	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic              hit;
		logic [IDX_W-1:0]  result_index;
		logic [CNT_W-1:0]  entry_count;
	} olst_res_t;

endpackage

// ===== design/olst_mem.sv =====
module olst_mem #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// single write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/olst_seq.sv =====
module olst_seq #(
	parameter int CAPACITY   = 64,
	parameter int KEY_BITS   = 64,
	parameter int VALUE_BITS = 64
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [olst_pkg::CMD_W-1:0]            cmd,
	input  logic [olst_pkg::POS_W-1:0]            position,
	input  logic [olst_pkg::WORD_W-1:0]           entry_key,
	input  logic [olst_pkg::WORD_W-1:0]           entry_value,
	input  logic                                  out_free,
	output logic                                  res_valid,
	output olst_pkg::olst_res_t                   res,
	output logic [KEY_BITS-1:0]                   res_key,
	output logic [VALUE_BITS-1:0]                 res_value,
	output logic                                  mem_we,
	output logic [$clog2(CAPACITY)-1:0]           mem_waddr,
	output logic [KEY_BITS+VALUE_BITS-1:0]        mem_wdata,
	output logic                                  mem_re,
	output logic [$clog2(CAPACITY)-1:0]           mem_raddr,
	input  logic [KEY_BITS+VALUE_BITS-1:0]        mem_rdata
);
	import olst_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > POS_W) ? CW : POS_W;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_SHIFT_UP = 3'd1;
	localparam logic [2:0] S_SHIFT_DN = 3'd2;
	localparam logic [2:0] S_FIND     = 3'd3;
	localparam logic [2:0] S_READ     = 3'd4;
	localparam logic [2:0] S_DONE     = 3'd5;

	logic [2:0]            state_q;
	logic [CW-1:0]         count_q;
	logic [AW-1:0]         ptr_q;
	logic [AW-1:0]         at_q;
	logic                  issue_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic                  rd_pend_s1;
	logic [AW-1:0]         rd_addr_s1;
	logic [STAT_W-1:0]     status_q;
	logic                  hit_q;
	logic [IDX_W-1:0]      idx_q;
	logic [KEY_BITS-1:0]   rkey_q;
	logic [VALUE_BITS-1:0] rval_q;

	logic                  accept;
	logic [KEY_BITS-1:0]   in_key;
	logic [VALUE_BITS-1:0] in_val;
	logic [PW-1:0]         cnt_p;
	logic [PW-1:0]         pos_p;
	logic [PW-1:0]         at_p;
	logic                  full;
	logic                  empty;
	logic [AW-1:0]         last_a;
	logic [KEY_BITS-1:0]   rd_key;
	logic                  match;
	logic                  ins_cmd;

	assign accept   = in_valid && (state_q == S_IDLE);
	assign in_stall = (state_q != S_IDLE);
	assign in_key   = entry_key[KEY_BITS-1:0];
	assign in_val   = entry_value[VALUE_BITS-1:0];
	assign cnt_p    = PW'(count_q);
	assign pos_p    = PW'(position);
	assign full     = (count_q == CW'(CAPACITY));
	assign empty    = (count_q == '0);
	assign last_a   = AW'(count_q - CW'(1));
	assign rd_key   = mem_rdata[VALUE_BITS +: KEY_BITS];
	assign match    = rd_pend_s1 && (state_q == S_FIND) && (rd_key == key_q);
	assign ins_cmd  = (cmd == CMD_PUSH_TAIL) || (cmd == CMD_PUSH_HEAD) ||
	                  (cmd == CMD_INSERT_AT);

	// target index of the request
	always_comb begin
		case (cmd)
			CMD_PUSH_TAIL: at_p = cnt_p;
			CMD_PUSH_HEAD: at_p = '0;
			CMD_POP_HEAD:  at_p = '0;
			default:       at_p = pos_p;
		endcase
	end

	// memory port control: reads run one entry ahead of the write-back
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = at_q;
		mem_wdata = {key_q, val_q};
		mem_re    = 1'b0;
		mem_raddr = ptr_q;
		case (state_q)
			S_IDLE: begin
				if (accept && ins_cmd && !full && (at_p == cnt_p)) begin
					mem_we    = 1'b1;
					mem_waddr = AW'(count_q);
					mem_wdata = {in_key, in_val};
				end
				if (accept && (cmd == CMD_READ_AT) && (pos_p < cnt_p)) begin
					mem_re    = 1'b1;
					mem_raddr = AW'(position);
				end
			end
			S_SHIFT_UP: begin
				mem_re = issue_q;
				if (rd_pend_s1) begin
					mem_we    = 1'b1;
					mem_waddr = rd_addr_s1 + AW'(1);
					mem_wdata = mem_rdata;
				end else if (!issue_q) begin
					mem_we = 1'b1;
				end
			end
			S_SHIFT_DN: begin
				mem_re = issue_q;
				if (rd_pend_s1) begin
					mem_we    = 1'b1;
					mem_waddr = rd_addr_s1 - AW'(1);
					mem_wdata = mem_rdata;
				end
			end
			S_FIND: begin
				mem_re = issue_q;
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			issue_q    <= 1'b0;
			rd_pend_s1 <= 1'b0;
		end else begin
			rd_pend_s1 <= mem_re;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DONE;
						case (cmd)
							CMD_PUSH_TAIL, CMD_PUSH_HEAD, CMD_INSERT_AT: begin
								if (!full && (at_p == cnt_p)) begin
									count_q <= count_q + CW'(1);
								end else if (!full && (at_p < cnt_p)) begin
									at_q    <= AW'(at_p);
									ptr_q   <= last_a;
									issue_q <= 1'b1;
									state_q <= S_SHIFT_UP;
								end
							end
							CMD_POP_TAIL: begin
								if (!empty) begin
									count_q <= count_q - CW'(1);
								end
							end
							CMD_POP_HEAD, CMD_REMOVE_AT: begin
								if (!empty && (at_p == cnt_p - PW'(1))) begin
									count_q <= count_q - CW'(1);
								end else if (!empty && (at_p < cnt_p)) begin
									ptr_q   <= AW'(at_p) + AW'(1);
									issue_q <= 1'b1;
									state_q <= S_SHIFT_DN;
								end
							end
							CMD_FIND: begin
								if (!empty) begin
									ptr_q   <= '0;
									issue_q <= 1'b1;
									state_q <= S_FIND;
								end
							end
							CMD_READ_AT: begin
								if (pos_p < cnt_p) begin
									state_q <= S_READ;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SHIFT_UP: begin
					if (issue_q) begin
						if (ptr_q == at_q) begin
							issue_q <= 1'b0;
						end else begin
							ptr_q <= ptr_q - AW'(1);
						end
					end else if (!rd_pend_s1) begin
						count_q <= count_q + CW'(1);
						state_q <= S_DONE;
					end
				end
				S_SHIFT_DN: begin
					if (issue_q) begin
						if (ptr_q == last_a) begin
							issue_q <= 1'b0;
						end else begin
							ptr_q <= ptr_q + AW'(1);
						end
					end else if (!rd_pend_s1) begin
						count_q <= count_q - CW'(1);
						state_q <= S_DONE;
					end
				end
				S_FIND: begin
					if (issue_q) begin
						if (ptr_q == last_a) begin
							issue_q <= 1'b0;
						end else begin
							ptr_q <= ptr_q + AW'(1);
						end
					end
					if (match || (rd_pend_s1 && (rd_addr_s1 == last_a))) begin
						issue_q <= 1'b0;
						state_q <= S_DONE;
					end
				end
				S_READ: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request payload and result fields
	always_ff @(posedge clk) begin
		rd_addr_s1 <= mem_raddr;
		if (accept) begin
			key_q  <= in_key;
			val_q  <= in_val;
			hit_q  <= 1'b0;
			idx_q  <= '0;
			rkey_q <= '0;
			rval_q <= '0;
			if (ins_cmd && full) begin
				status_q <= STAT_FULL;
			end else if (ins_cmd && (at_p > cnt_p)) begin
				status_q <= STAT_BADPOS;
			end else if (!ins_cmd && (cmd != CMD_FIND) && (cmd != CMD_READ_AT) && empty) begin
				status_q <= STAT_EMPTY;
			end else if (((cmd == CMD_REMOVE_AT) || (cmd == CMD_READ_AT)) &&
			             (pos_p >= cnt_p)) begin
				status_q <= STAT_BADPOS;
			end else begin
				status_q <= STAT_OK;
			end
		end
		if (match && (state_q == S_FIND)) begin
			hit_q <= 1'b1;
			idx_q <= IDX_W'(rd_addr_s1);
		end
		if (state_q == S_READ) begin
			rkey_q <= rd_key;
			rval_q <= mem_rdata[VALUE_BITS-1:0];
		end
	end

	assign res_valid          = (state_q == S_DONE);
	assign res.status         = status_q;
	assign res.hit            = hit_q;
	assign res.result_index   = idx_q;
	assign res.entry_count    = CNT_W'(count_q);
	assign res_key            = rkey_q;
	assign res_value          = rval_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("fill count above capacity");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re && (mem_waddr == mem_raddr)))
		else $error("read and write of the same entry in one cycle");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !out_free) |=> (res_valid && $stable(count_q)))
		else $error("result dropped while output busy");

	a_dn_range: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && (state_q == S_SHIFT_DN)) |-> (CW'(mem_waddr) < count_q - CW'(1)))
		else $error("remove shift wrote past the last kept entry");

endmodule

// ===== design/ordered_list_engine.sv =====
// Ordered list engine: a list of up to CAPACITY key/value entries held in
// one single-port-write, registered-read memory, plus a fill count.
// Request channel (in_valid/in_stall): cmd, position, entry_key,
// entry_value. One request is taken when in_valid is high and in_stall low.
// Result channel (out_valid/out_stall): status, hit, result_index,
// read_key, read_value, entry_count. Exactly one result per request.
// Requests at the tail end, refused requests and an empty find go straight
// to the result; read_at first reads the entry from memory; insert and
// remove first shift the later entries up or down; find scans from index 0
// until a match or the last entry.
// The entry shifts and the find scan go through the memory one entry per
// cycle, so the memory port sets the cost. One request is worked at a time;
// a new request is taken as soon as the previous result has entered the
// output register, even while that result is still stalled.
// Reset clears the fill count and the handshake state; memory contents are
// not cleared. A stalled result is held, and the sequencer waits in its
// final state until the output register frees up.
module ordered_list_engine #(
	parameter int CAPACITY   = 64,
	parameter int KEY_BITS   = 64,
	parameter int VALUE_BITS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [olst_pkg::CMD_W-1:0]    cmd,
	input  logic [olst_pkg::POS_W-1:0]    position,
	input  logic [olst_pkg::WORD_W-1:0]   entry_key,
	input  logic [olst_pkg::WORD_W-1:0]   entry_value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [olst_pkg::STAT_W-1:0]   status,
	output logic                          hit,
	output logic [olst_pkg::IDX_W-1:0]    result_index,
	output logic [olst_pkg::WORD_W-1:0]   read_key,
	output logic [olst_pkg::WORD_W-1:0]   read_value,
	output logic [olst_pkg::CNT_W-1:0]    entry_count
);
	import olst_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int EW = KEY_BITS + VALUE_BITS;

	logic                  out_valid_q;
	logic                  out_free;
	logic                  res_valid;
	olst_res_t             res;
	olst_res_t             res_q;
	logic [KEY_BITS-1:0]   res_key;
	logic [VALUE_BITS-1:0] res_value;
	logic [KEY_BITS-1:0]   rkey_q;
	logic [VALUE_BITS-1:0] rval_q;
	logic                  mem_we;
	logic [AW-1:0]         mem_waddr;
	logic [EW-1:0]         mem_wdata;
	logic                  mem_re;
	logic [AW-1:0]         mem_raddr;
	logic [EW-1:0]         mem_rdata;

	assign out_free = !out_valid_q || !out_stall;

	olst_seq #(
		.CAPACITY   (CAPACITY),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.position    (position),
		.entry_key   (entry_key),
		.entry_value (entry_value),
		.out_free    (out_free),
		.res_valid   (res_valid),
		.res         (res),
		.res_key     (res_key),
		.res_value   (res_value),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_re      (mem_re),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata)
	);

	olst_mem #(
		.DEPTH (CAPACITY),
		.WIDTH (EW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (res_valid && out_free) begin
			res_q  <= res;
			rkey_q <= res_key;
			rval_q <= res_value;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = res_q.status;
	assign hit          = res_q.hit;
	assign result_index = res_q.result_index;
	assign entry_count  = res_q.entry_count;
	assign read_key     = WORD_W'(rkey_q);
	assign read_value   = WORD_W'(rval_q);

endmodule

// ===== bench/olst_check_pkg.sv =====
package olst_check_pkg;

	import olst_pkg::*;

	localparam int LIST_DEPTH = 64;

	// one expected result, one field per output port
	typedef struct {
		logic [STAT_W-1:0] status;
		logic              hit;
		logic [IDX_W-1:0]  result_index;
		logic [WORD_W-1:0] read_key;
		logic [WORD_W-1:0] read_value;
		logic [CNT_W-1:0]  entry_count;
	} list_result_t;

	// Shadow copy of the list: predicts each result from the accepted
	// requests and holds the predictions until the block delivers them.
	class list_scoreboard;

		logic [WORD_W-1:0] keys [LIST_DEPTH];
		logic [WORD_W-1:0] values [LIST_DEPTH];
		int unsigned       fill;
		list_result_t      awaited [$];
		int unsigned       errors;

		function new();
			fill = 0;
			errors = 0;
		endfunction

		// apply one accepted request to the shadow list and queue its result
		function void note_request(logic [CMD_W-1:0] op, logic [POS_W-1:0] pos,
			logic [WORD_W-1:0] key, logic [WORD_W-1:0] value);
			list_result_t r;
			int unsigned  at;
			int unsigned  i;
			r = '{status: STAT_OK, hit: 1'b0, result_index: '0, read_key: '0,
				read_value: '0, entry_count: '0};
			case (op)
				CMD_PUSH_TAIL, CMD_PUSH_HEAD, CMD_INSERT_AT: begin
					at = (op == CMD_PUSH_TAIL) ? fill : (op == CMD_PUSH_HEAD) ? 0 : pos;
					// full is reported ahead of a bad position
					if (fill >= LIST_DEPTH) begin
						r.status = STAT_FULL;
					end else if (at > fill) begin
						r.status = STAT_BADPOS;
					end else begin
						for (i = fill; i > at; i--) begin
							keys[i] = keys[i-1];
							values[i] = values[i-1];
						end
						keys[at] = key;
						values[at] = value;
						fill++;
					end
				end
				CMD_POP_TAIL, CMD_POP_HEAD, CMD_REMOVE_AT: begin
					// empty is reported ahead of a bad position
					if (fill == 0) begin
						r.status = STAT_EMPTY;
					end else if (op == CMD_REMOVE_AT && pos >= fill) begin
						r.status = STAT_BADPOS;
					end else begin
						at = (op == CMD_POP_TAIL) ? fill - 1 : (op == CMD_POP_HEAD) ? 0 : pos;
						for (i = at; i + 1 < fill; i++) begin
							keys[i] = keys[i+1];
							values[i] = values[i+1];
						end
						fill--;
					end
				end
				CMD_FIND: begin
					// first match wins; a miss leaves hit and index at zero
					for (i = 0; i < fill; i++) begin
						if (keys[i] == key) begin
							r.hit = 1'b1;
							r.result_index = IDX_W'(i);
							break;
						end
					end
				end
				default: begin
					if (pos >= fill) begin
						r.status = STAT_BADPOS;
					end else begin
						r.read_key = keys[pos];
						r.read_value = values[pos];
					end
				end
			endcase
			r.entry_count = CNT_W'(fill);
			awaited.push_back(r);
		endfunction

		function void compare_field(string name, logic [WORD_W-1:0] want,
			logic [WORD_W-1:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		// match one delivered result against the oldest prediction
		function void check_result(logic [STAT_W-1:0] status, logic hit,
			logic [IDX_W-1:0] result_index, logic [WORD_W-1:0] read_key,
			logic [WORD_W-1:0] read_value, logic [CNT_W-1:0] entry_count);
			list_result_t e;
			if (awaited.size() == 0) begin
				$error("result with no request outstanding: status %0d, entry_count %0d",
					status, entry_count);
				errors++;
				return;
			end
			e = awaited.pop_front();
			compare_field("status", e.status, status);
			compare_field("hit", e.hit, hit);
			compare_field("result_index", e.result_index, result_index);
			compare_field("read_key", e.read_key, read_key);
			compare_field("read_value", e.read_value, read_value);
			compare_field("entry_count", e.entry_count, entry_count);
		endfunction

		function int unsigned outstanding();
			return awaited.size();
		endfunction

	endclass

endpackage

// ===== bench/ordered_list_engine_tb.sv =====
module ordered_list_engine_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import olst_pkg::*;
	import olst_check_pkg::*;

	localparam int RANDOM_REQUESTS = 1430;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int DRAIN_CYCLES    = 80;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [CMD_W-1:0]    cmd;
	logic [POS_W-1:0]    position;
	logic [WORD_W-1:0]   entry_key;
	logic [WORD_W-1:0]   entry_value;
	logic                out_valid;
	logic                out_stall;
	logic [STAT_W-1:0]   status;
	logic                hit;
	logic [IDX_W-1:0]    result_index;
	logic [WORD_W-1:0]   read_key;
	logic [WORD_W-1:0]   read_value;
	logic [CNT_W-1:0]    entry_count;

	// 0: sender idles lightly, 1: receiver idles lightly, 2: no random idling
	int unsigned    stage;
	list_scoreboard board = new();

	ordered_list_engine dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.position     (position),
		.entry_key    (entry_key),
		.entry_value  (entry_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.hit          (hit),
		.result_index (result_index),
		.read_key     (read_key),
		.read_value   (read_value),
		.entry_count  (entry_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// offer one request from a falling edge and hold it until accepted
	task automatic send_request(input logic [CMD_W-1:0] op, input logic [POS_W-1:0] pos,
		input logic [WORD_W-1:0] key, input logic [WORD_W-1:0] value);
		int unsigned pct;
		pct = (stage == 0) ? 37 : (stage == 1) ? 64 : 0;
		while ($urandom_range(99) < pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		position <= pos;
		entry_key <= key;
		entry_value <= value;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.note_request(op, pos, key, value);
		@(negedge clk);
	endtask

	// result side: check at the rising edge, decide the stall at the falling edge
	initial begin
		int unsigned hold_left;
		int unsigned pct;
		bit          held;
		out_stall = 1'b0;
		hold_left = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				board.check_result(status, hit, result_index, read_key, read_value,
					entry_count);
			@(negedge clk);
			// one long hold-off so the engine backs up onto its request side
			if (stage == 2 && !held) begin
				held = 1'b1;
				hold_left = HOLD_OFF_CYCLES;
			end
			pct = (stage == 0) ? 64 : (stage == 1) ? 37 : 0;
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < pct);
			end
		end
	end

	// end the run if neither channel moves for too long
	initial begin
		int unsigned quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		logic [WORD_W-1:0] key_pool [8];
		logic [CMD_W-1:0]  op;
		logic [POS_W-1:0]  pos;
		logic [WORD_W-1:0] key;
		int unsigned       roll;
		bit                grow;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_PUSH_TAIL;
		position = '0;
		entry_key = '0;
		entry_value = '0;
		stage = 0;
		grow = 1'b1;
		foreach (key_pool[k])
			key_pool[k] = {$urandom, $urandom};
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty list, bounds, extremes of key and value, first match
		send_request(CMD_POP_TAIL, 6'd0, '0, '0);
		send_request(CMD_POP_HEAD, 6'd63, '0, '0);
		send_request(CMD_REMOVE_AT, 6'd0, '0, '0);
		send_request(CMD_READ_AT, 6'd0, '0, '0);
		send_request(CMD_FIND, 6'd0, '1, '0);
		send_request(CMD_INSERT_AT, 6'd1, '1, '1);
		send_request(CMD_PUSH_TAIL, 6'd0, '1, '0);
		send_request(CMD_PUSH_HEAD, 6'd63, '0, '1);
		send_request(CMD_INSERT_AT, 6'd2, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
		send_request(CMD_INSERT_AT, 6'd1, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
		send_request(CMD_PUSH_TAIL, 6'd0, 64'hAAAA_AAAA_AAAA_AAAA, '1);
		send_request(CMD_FIND, 6'd0, 64'hAAAA_AAAA_AAAA_AAAA, '0);
		send_request(CMD_FIND, 6'd0, 64'd1, '0);
		send_request(CMD_READ_AT, 6'd4, '0, '0);
		send_request(CMD_READ_AT, 6'd5, '0, '0);
		send_request(CMD_READ_AT, 6'd63, '0, '0);
		send_request(CMD_REMOVE_AT, 6'd5, '0, '0);
		send_request(CMD_REMOVE_AT, 6'd63, '0, '0);
		send_request(CMD_INSERT_AT, 6'd63, '1, '1);
		send_request(CMD_REMOVE_AT, 6'd1, '0, '0);
		send_request(CMD_POP_HEAD, 6'd0, '0, '0);
		send_request(CMD_POP_TAIL, 6'd0, '0, '0);
		send_request(CMD_READ_AT, 6'd0, '0, '0);
		send_request(CMD_FIND, 6'd0, '1, '0);

		// random: alternate growing and draining the list so that full and
		// empty are both reached; keys often repeat so finds hit
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			stage = (n * 3) / RANDOM_REQUESTS;
			if (grow && board.fill == LIST_DEPTH && $urandom_range(5) == 0)
				grow = 1'b0;
			if (!grow && board.fill == 0 && $urandom_range(5) == 0)
				grow = 1'b1;
			roll = $urandom_range(99);
			if (roll < 10) begin
				op = CMD_W'($urandom_range(7));
			end else if (roll < (grow ? 60 : 25)) begin
				case ($urandom_range(2))
					0: op = CMD_PUSH_TAIL;
					1: op = CMD_PUSH_HEAD;
					default: op = CMD_INSERT_AT;
				endcase
			end else if (roll < 80) begin
				case ($urandom_range(2))
					0: op = CMD_POP_TAIL;
					1: op = CMD_POP_HEAD;
					default: op = CMD_REMOVE_AT;
				endcase
			end else if (roll < 90) begin
				op = CMD_FIND;
			end else begin
				op = CMD_READ_AT;
			end
			// mostly a position inside the list, sometimes anywhere
			if (roll < 10 || $urandom_range(7) == 0)
				pos = POS_W'($urandom_range(63));
			else if (op == CMD_INSERT_AT)
				pos = POS_W'($urandom_range(board.fill));
			else
				pos = (board.fill == 0) ? '0 : POS_W'($urandom_range(board.fill - 1));
			key = $urandom_range(1) ? key_pool[$urandom_range(7)] : {$urandom, $urandom};
			send_request(op, pos, key, {$urandom, $urandom});
		end
		in_valid <= 1'b0;

		while (board.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/olst_pkg.sv
design/olst_mem.sv
design/olst_seq.sv
design/ordered_list_engine.sv
bench/olst_check_pkg.sv
bench/ordered_list_engine_tb.sv
